// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Concurrent assertion, clocked on the rising edge, disabled during active-low reset.
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Default clock and reset of this project.
`define ASSERT_STD(lbl, prop, msg) \
  `ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)
`endif

// ----- hw/rtl/apf_pkg.sv -----
// Package of the articulation point finder: widths, codes and the stack entry type.
`default_nettype none
package apf_pkg;
  localparam int unsigned VtxW = 6;
  localparam int unsigned CntW = 7;
  localparam int unsigned MaxVerticesDef = 64;
  localparam logic [CntW-1:0] NoParent = 7'd127;
  localparam logic [CntW-1:0] VertexCountReset = 7'd64;

  typedef struct packed {
    logic [VtxW-1:0] vertex;
    logic [CntW-1:0] parent;
    logic [CntW-1:0] scan;
  } stack_entry_t;
endpackage
`default_nettype wire

// ----- hw/rtl/articulation_point_finder_core.sv -----
// Top level of the articulation point finder: edge loading, depth-first search, result output.
`default_nettype none
`include "assert_macros.svh"
// Articulation point finder. Edges are requested one per start pulse while busy is low; an
// edge with both endpoints in range is written in S_IDLE and S_EDGE2 (one bit into each
// adjacency row), any other request is taken in S_IDLE alone. A request with last_item set
// starts the search: busy stays high while an iterative DFS runs from every unvisited vertex
// in ascending order. The search scans one adjacency bit per cycle of the current vertex,
// pausing where a tree edge enters a child (row load in S_LOAD) or a back edge is met
// (discovery time read in S_BACK); a return to a parent goes through S_POP1, S_POP2, S_POP3.
// The output pass then steps one vertex per cycle from vertex 0 up to the highest cut vertex
// and puts out a result on result_valid_o at each cut vertex, in ascending order, with
// last_result_o on the final one, or a single none_found_o result. There is no stall on the
// result side: each result is valid for one cycle only and must be taken then. Adjacency,
// discovery times, low links and the DFS stack live in synchronous memories; the adjacency
// rows carry flop valid bits so the matrix is cleared at once after each run, no sweep.
// vertex_count may be written whenever the block is idle (cfg_ready_o is low while busy).
module articulation_point_finder_core #(
  parameter int unsigned MAX_VERTICES = apf_pkg::MaxVerticesDef
) (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       start,
  output logic                      busy,
  input  wire  [apf_pkg::VtxW-1:0]  edge_from_i,
  input  wire  [apf_pkg::VtxW-1:0]  edge_to_i,
  input  wire                       has_edge_i,
  input  wire                       last_item_i,
  input  wire                       cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire  [apf_pkg::CntW-1:0]  cfg_data_i,
  output logic                      result_valid_o,
  output logic [apf_pkg::VtxW-1:0]  cut_vertex_o,
  output logic                      none_found_o,
  output logic                      last_result_o
);
  localparam int unsigned VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int unsigned CW = apf_pkg::CntW;
  localparam logic [CW-1:0] MaxCnt = CW'(MAX_VERTICES);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_EDGE2 = 4'd1;
  localparam logic [3:0] S_ROOT  = 4'd2;
  localparam logic [3:0] S_LOAD  = 4'd3;
  localparam logic [3:0] S_SCAN  = 4'd4;
  localparam logic [3:0] S_BACK  = 4'd5;
  localparam logic [3:0] S_POP1  = 4'd6;
  localparam logic [3:0] S_POP2  = 4'd7;
  localparam logic [3:0] S_POP3  = 4'd8;
  localparam logic [3:0] S_EMIT  = 4'd9;

  // Memories.
  logic [MAX_VERTICES-1:0]   adj_mem  [MAX_VERTICES];
  logic [apf_pkg::VtxW-1:0]  disc_mem [MAX_VERTICES];
  logic [apf_pkg::VtxW-1:0]  low_mem  [MAX_VERTICES];
  apf_pkg::stack_entry_t     stk_mem  [MAX_VERTICES];

  logic                      adj_we, adj_wfull;
  logic [VW-1:0]             adj_waddr, adj_wbit, adj_raddr;
  logic [MAX_VERTICES-1:0]   adj_rd_q;
  logic                      disc_we;
  logic [VW-1:0]             disc_waddr, disc_raddr;
  logic [apf_pkg::VtxW-1:0]  disc_wdata, disc_rd_q;
  logic                      low_we;
  logic [VW-1:0]             low_waddr, low_raddr;
  logic [apf_pkg::VtxW-1:0]  low_wdata, low_rd_q;
  logic                      stk_we;
  logic [VW-1:0]             stk_waddr, stk_raddr;
  apf_pkg::stack_entry_t     stk_wdata, stk_rd_q;

  // Control and search registers.
  logic [3:0]                state_q, state_d;
  logic [CW-1:0]             vcount_q;
  logic [MAX_VERTICES-1:0]   rv_q, rv_d;        // adjacency row valid
  logic [MAX_VERTICES-1:0]   visited_q, visited_d;
  logic [MAX_VERTICES-1:0]   cut_q, cut_d;
  logic [CW-1:0]             clock_q, clock_d;
  logic [CW-1:0]             depth_q, depth_d;
  logic [1:0]                rcc_q, rcc_d;
  logic [CW-1:0]             root_q, root_d;
  logic [VW-1:0]             emit_q, emit_d;
  logic                      lastin_q, lastin_d;
  logic [VW-1:0]             ea_q, ea_d, eb_q, eb_d;
  logic [apf_pkg::VtxW-1:0]  v_q, v_d;
  logic [CW-1:0]             par_q, par_d;
  logic [CW-1:0]             w_q, w_d;
  logic [MAX_VERTICES-1:0]   row_q, row_d;
  logic [apf_pkg::VtxW-1:0]  lowv_q, lowv_d;
  logic [apf_pkg::VtxW-1:0]  clow_q, clow_d;
  logic                      rvalid_q, rvalid_d;
  logic [apf_pkg::VtxW-1:0]  rvtx_q, rvtx_d;
  logic                      rnone_q, rnone_d, rlast_q, rlast_d;

  logic [CW-1:0]             cnt;
  logic                      edge_ok;
  logic [VW-1:0]             widx, vidx, ridx;
  logic [MAX_VERTICES-1:0]   cut_hi;
  apf_pkg::stack_entry_t     ent;

  assign cnt         = (vcount_q > MaxCnt) ? MaxCnt : vcount_q;
  assign edge_ok     = has_edge_i && ({1'b0, edge_from_i} < cnt) && ({1'b0, edge_to_i} < cnt);
  assign widx        = w_q[VW-1:0];
  assign vidx        = v_q[VW-1:0];
  assign ridx        = root_q[VW-1:0];
  assign cut_hi      = cut_q >> emit_q;
  assign ent         = stk_rd_q;
  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = (state_q == S_IDLE);

  assign result_valid_o = rvalid_q;
  assign cut_vertex_o   = rvtx_q;
  assign none_found_o   = rnone_q;
  assign last_result_o  = rlast_q;

  always_comb begin
    state_d   = state_q;
    rv_d      = rv_q;
    visited_d = visited_q;
    cut_d     = cut_q;
    clock_d   = clock_q;
    depth_d   = depth_q;
    rcc_d     = rcc_q;
    root_d    = root_q;
    emit_d    = emit_q;
    lastin_d  = lastin_q;
    ea_d      = ea_q;
    eb_d      = eb_q;
    v_d       = v_q;
    par_d     = par_q;
    w_d       = w_q;
    row_d     = row_q;
    lowv_d    = lowv_q;
    clow_d    = clow_q;
    rvalid_d  = 1'b0;
    rvtx_d    = rvtx_q;
    rnone_d   = rnone_q;
    rlast_d   = rlast_q;

    adj_we     = 1'b0;
    adj_wfull  = 1'b0;
    adj_waddr  = ea_q;
    adj_wbit   = eb_q;
    adj_raddr  = vidx;
    disc_we    = 1'b0;
    disc_waddr = widx;
    disc_wdata = clock_q[apf_pkg::VtxW-1:0];
    disc_raddr = widx;
    low_we     = 1'b0;
    low_waddr  = vidx;
    low_wdata  = lowv_q;
    low_raddr  = vidx;
    stk_we     = 1'b0;
    stk_waddr  = VW'(depth_q - 7'd1);
    stk_wdata  = '{vertex: v_q, parent: par_q, scan: CW'(w_q + 7'd1)};
    stk_raddr  = VW'(depth_q - 7'd2);

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          lastin_d = last_item_i;
          ea_d     = edge_from_i[VW-1:0];
          eb_d     = edge_to_i[VW-1:0];
          if (edge_ok) begin
            adj_we    = 1'b1;
            adj_waddr = edge_from_i[VW-1:0];
            adj_wbit  = edge_to_i[VW-1:0];
            adj_wfull = !rv_q[edge_from_i[VW-1:0]];
            rv_d[edge_from_i[VW-1:0]] = 1'b1;
            state_d   = S_EDGE2;
          end else if (last_item_i) begin
            state_d = S_ROOT;
          end
        end
      end
      S_EDGE2: begin
        // mirror bit; row valid already reflects the first write
        adj_we    = 1'b1;
        adj_waddr = eb_q;
        adj_wbit  = ea_q;
        adj_wfull = !rv_q[eb_q];
        rv_d[eb_q] = 1'b1;
        state_d   = lastin_q ? S_ROOT : S_IDLE;
      end
      S_ROOT: begin
        if (root_q >= cnt) begin
          emit_d  = '0;
          state_d = S_EMIT;
        end else if (visited_q[ridx]) begin
          root_d = CW'(root_q + 7'd1);
        end else begin
          disc_we    = 1'b1;
          disc_waddr = ridx;
          visited_d[ridx] = 1'b1;
          v_d       = apf_pkg::VtxW'(root_q);
          par_d     = apf_pkg::NoParent;
          w_d       = '0;
          lowv_d    = clock_q[apf_pkg::VtxW-1:0];
          clock_d   = CW'(clock_q + 7'd1);
          depth_d   = 7'd1;
          rcc_d     = '0;
          adj_raddr = ridx;
          state_d   = S_LOAD;
        end
      end
      S_LOAD: begin
        row_d   = rv_q[vidx] ? adj_rd_q : '0;
        state_d = S_SCAN;
      end
      S_SCAN: begin
        if (w_q >= cnt) begin
          state_d = S_POP1;
        end else if (row_q[widx] && (w_q != par_q)) begin
          w_d = CW'(w_q + 7'd1);
          if (!visited_q[widx]) begin
            // push: spill current top, open the child
            stk_we  = 1'b1;
            low_we  = 1'b1;
            disc_we = 1'b1;
            visited_d[widx] = 1'b1;
            clock_d   = CW'(clock_q + 7'd1);
            v_d       = apf_pkg::VtxW'(w_q);
            par_d     = CW'(v_q);
            w_d       = '0;
            lowv_d    = clock_q[apf_pkg::VtxW-1:0];
            depth_d   = CW'(depth_q + 7'd1);
            adj_raddr = widx;
            state_d   = S_LOAD;
          end else begin
            state_d = S_BACK;
          end
        end else begin
          w_d = CW'(w_q + 7'd1);
        end
      end
      S_BACK: begin
        if (disc_rd_q < lowv_q) lowv_d = disc_rd_q;
        state_d = S_SCAN;
      end
      S_POP1: begin
        if (depth_q == 7'd1) begin
          depth_d = '0;
          if (rcc_q == 2'd2) cut_d[ridx] = 1'b1;
          root_d  = CW'(root_q + 7'd1);
          state_d = S_ROOT;
        end else begin
          clow_d  = lowv_q;
          depth_d = CW'(depth_q - 7'd1);
          state_d = S_POP2;
        end
      end
      S_POP2: begin
        v_d        = ent.vertex;
        par_d      = ent.parent;
        w_d        = ent.scan;
        low_raddr  = ent.vertex[VW-1:0];
        disc_raddr = ent.vertex[VW-1:0];
        adj_raddr  = ent.vertex[VW-1:0];
        state_d    = S_POP3;
      end
      S_POP3: begin
        row_d  = rv_q[vidx] ? adj_rd_q : '0;
        lowv_d = (clow_q < low_rd_q) ? clow_q : low_rd_q;
        if (depth_q == 7'd1) begin
          if (rcc_q != 2'd2) rcc_d = rcc_q + 2'd1;
        end else if (clow_q >= disc_rd_q) begin
          cut_d[vidx] = 1'b1;
        end
        state_d = S_SCAN;
      end
      S_EMIT: begin
        if (cut_q == '0) begin
          rvalid_d = 1'b1;
          rvtx_d   = '0;
          rnone_d  = 1'b1;
          rlast_d  = 1'b1;
          state_d  = S_IDLE;
        end else if (cut_q[emit_q]) begin
          rvalid_d = 1'b1;
          rvtx_d   = apf_pkg::VtxW'(emit_q);
          rnone_d  = 1'b0;
          rlast_d  = ~|cut_hi[MAX_VERTICES-1:1];
          if (~|cut_hi[MAX_VERTICES-1:1]) state_d = S_IDLE;
          else emit_d = VW'(emit_q + 1'b1);
        end else begin
          emit_d = VW'(emit_q + 1'b1);
        end
        if (state_d == S_IDLE) begin
          // run done: drop the matrix and reset the visit, cut, clock, depth and root state
          rv_d      = '0;
          visited_d = '0;
          cut_d     = '0;
          clock_d   = '0;
          depth_d   = '0;
          rcc_d     = '0;
          root_d    = '0;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      vcount_q  <= apf_pkg::VertexCountReset;
      rv_q      <= '0;
      visited_q <= '0;
      cut_q     <= '0;
      clock_q   <= '0;
      depth_q   <= '0;
      rcc_q     <= '0;
      root_q    <= '0;
      emit_q    <= '0;
      lastin_q  <= 1'b0;
      rvalid_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      if (cfg_valid_i && cfg_ready_o) vcount_q <= cfg_data_i;
      rv_q      <= rv_d;
      visited_q <= visited_d;
      cut_q     <= cut_d;
      clock_q   <= clock_d;
      depth_q   <= depth_d;
      rcc_q     <= rcc_d;
      root_q    <= root_d;
      emit_q    <= emit_d;
      lastin_q  <= lastin_d;
      rvalid_q  <= rvalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ea_q   <= ea_d;
    eb_q   <= eb_d;
    v_q    <= v_d;
    par_q  <= par_d;
    w_q    <= w_d;
    row_q  <= row_d;
    lowv_q <= lowv_d;
    clow_q <= clow_d;
    rvtx_q <= rvtx_d;
    rnone_q <= rnone_d;
    rlast_q <= rlast_d;
  end

  // Adjacency: a row not yet valid is written whole as a one-hot word.
  always_ff @(posedge clk_i) begin
    if (adj_we) begin
      if (adj_wfull) adj_mem[adj_waddr] <= MAX_VERTICES'(1) << adj_wbit;
      else adj_mem[adj_waddr][adj_wbit] <= 1'b1;
    end
    adj_rd_q <= adj_mem[adj_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (disc_we) disc_mem[disc_waddr] <= disc_wdata;
    disc_rd_q <= disc_mem[disc_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (low_we) low_mem[low_waddr] <= low_wdata;
    low_rd_q <= low_mem[low_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) stk_mem[stk_waddr] <= stk_wdata;
    stk_rd_q <= stk_mem[stk_raddr];
  end

  `ASSERT_STD(a_last_starts, (start && !busy && last_item_i) |=> busy, "last request not run")
  `ASSERT_STD(a_depth_bound, depth_q <= MaxCnt, "stack depth beyond vertex count")
  `ASSERT_STD(a_none_last, (rvalid_q && rnone_q) |-> rlast_q, "none found not last result")
  `ASSERT_STD(a_scan_stack, (state_q == S_SCAN) |-> (depth_q != '0), "scan with empty stack")
endmodule
`default_nettype wire

// ----- test/articulation_point_finder_core_checker.sv -----
// Checker for the articulation point finder: watches requests, predicts cut vertices, compares.
`timescale 1ns / 1ps
module articulation_point_finder_core_checker (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic                     busy_i,
  input  logic [apf_pkg::VtxW-1:0] edge_from_i,
  input  logic [apf_pkg::VtxW-1:0] edge_to_i,
  input  logic                     has_edge_i,
  input  logic                     last_item_i,
  input  logic                     cfg_valid_i,
  input  logic                     cfg_ready_i,
  input  logic [apf_pkg::CntW-1:0] cfg_data_i,
  input  logic                     result_valid_i,
  input  logic [apf_pkg::VtxW-1:0] cut_vertex_i,
  input  logic                     none_found_i,
  input  logic                     last_result_i,
  output int                       fail_count_o,
  output int                       pending_o,
  output int                       results_seen_o,
  output int                       graphs_seen_o
);
  typedef struct packed {
    logic [apf_pkg::VtxW-1:0] vtx;
    logic                     none;
    logic                     last;
  } cut_result_t;

  cut_result_t              expected_cuts[$];
  logic [63:0]              adj_rows[64];
  logic [apf_pkg::CntW-1:0] num_vertices;

  // search state
  logic [63:0]     seen_bits;
  logic [63:0]     cut_bits;
  logic [5:0]      disc_t[64];
  logic [5:0]      low_t[64];
  logic [5:0]      stk_vtx[64];
  logic [6:0]      stk_par[64];
  logic [6:0]      stk_pos[64];
  int              stk_depth;
  int              tick;
  int              root_kids;

  assign pending_o = expected_cuts.size();

  function automatic int live_count();
    return (num_vertices > 64) ? 64 : int'(num_vertices);
  endfunction

  task automatic enqueue_result(input cut_result_t r);
    expected_cuts = {expected_cuts, r};
  endtask

  task automatic visit(input int v, input int par);
    seen_bits[v] = 1'b1;
    disc_t[v] = tick[5:0];
    low_t[v] = tick[5:0];
    tick = (tick + 1) & 127;
    if (stk_depth < 64) begin
      stk_vtx[stk_depth] = v[5:0];
      stk_par[stk_depth] = par[6:0];
      stk_pos[stk_depth] = '0;
      stk_depth++;
    end
  endtask

  task automatic dfs_from(input int root, input int cnt);
    int t, v, par, w, p;
    bit hit;
    root_kids = 0;
    visit(root, int'(apf_pkg::NoParent));
    while (stk_depth > 0) begin
      t = stk_depth - 1;
      v = stk_vtx[t];
      par = stk_par[t];
      w = stk_pos[t];
      hit = 0;
      while (w < cnt) begin
        if (adj_rows[v][w] && w != par) begin
          hit = 1;
          break;
        end
        w++;
      end
      if (hit) begin
        stk_pos[t] = 7'(w + 1);
        if (!seen_bits[w]) visit(w, v);
        else if (disc_t[w] < low_t[v]) low_t[v] = disc_t[w];
        continue;
      end
      stk_depth--;
      if (stk_depth > 0) begin
        p = stk_vtx[stk_depth - 1];
        if (low_t[v] < low_t[p]) low_t[p] = low_t[v];
        if (stk_depth - 1 == 0) begin
          if (root_kids < 2) root_kids++;
        end else if (low_t[v] >= disc_t[p]) begin
          cut_bits[p] = 1'b1;
        end
      end
    end
    if (root_kids >= 2) cut_bits[root] = 1'b1;
  endtask

  // Full search over the loaded graph; queues the expected cut vertex list.
  task automatic predict_cuts();
    int cnt, n;
    cut_result_t r;
    cnt = live_count();
    seen_bits = '0;
    cut_bits = '0;
    tick = 0;
    stk_depth = 0;
    n = 0;
    for (int v = 0; v < cnt; v++)
      if (!seen_bits[v]) dfs_from(v, cnt);
    for (int v = 0; v < cnt; v++) begin
      if (cut_bits[v]) begin
        r.vtx = v[5:0];
        r.none = 1'b0;
        r.last = 1'b0;
        enqueue_result(r);
        n++;
      end
    end
    if (n == 0) begin
      r.vtx = '0;
      r.none = 1'b1;
      r.last = 1'b1;
      enqueue_result(r);
    end else begin
      expected_cuts[expected_cuts.size() - 1].last = 1'b1;
    end
    for (int i = 0; i < 64; i++) adj_rows[i] = '0;
  endtask

  task automatic report(input string what, input int want, input int got);
    $display("[%0t] mismatch on %s: expected %0d, got %0d", $time, what, want, got);
    fail_count_o++;
  endtask

  initial begin
    fail_count_o = 0;
    results_seen_o = 0;
    graphs_seen_o = 0;
    num_vertices = apf_pkg::VertexCountReset;
    for (int i = 0; i < 64; i++) adj_rows[i] = '0;
  end

  always @(posedge clk_i) begin
    cut_result_t want;
    if (rst_ni) begin
      if (start_i && !busy_i) begin
        if (has_edge_i && edge_from_i < live_count() && edge_to_i < live_count()) begin
          adj_rows[edge_from_i][edge_to_i] = 1'b1;
          adj_rows[edge_to_i][edge_from_i] = 1'b1;
        end
        if (last_item_i) begin
          predict_cuts();
          graphs_seen_o++;
        end
      end
      // the count takes effect after this edge, as in the block
      if (cfg_valid_i && cfg_ready_i) num_vertices = cfg_data_i;
      if (result_valid_i) begin
        results_seen_o++;
        if (expected_cuts.size() == 0) begin
          report("unexpected result", -1, int'(cut_vertex_i));
        end else begin
          want = expected_cuts.pop_front();
          if (want.vtx != cut_vertex_i) report("cut_vertex", want.vtx, cut_vertex_i);
          if (want.none != none_found_i) report("none_found", want.none, none_found_i);
          if (want.last != last_result_i) report("last_result", want.last, last_result_i);
        end
      end
    end
  end
endmodule

// ----- test/articulation_point_finder_core_tb.sv -----
// Testbench top for the articulation point finder: stimulus, pacing and verdict.
`timescale 1ns / 1ps
module articulation_point_finder_core_tb;
  localparam int CycleLimit = 1000000;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  logic [apf_pkg::VtxW-1:0] edge_from = '0;
  logic [apf_pkg::VtxW-1:0] edge_to = '0;
  logic                     has_edge = 1'b0;
  logic                     last_item = 1'b0;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [apf_pkg::CntW-1:0] cfg_data = '0;
  logic                     result_valid;
  logic [apf_pkg::VtxW-1:0] cut_vertex;
  logic                     none_found;
  logic                     last_result;

  int fail_count, pending, results_seen, graphs_seen;
  int cycles = 0;
  int requests_sent = 0;
  int burst_left = 0;
  bit steady = 0;          // no gaps while set
  int cur_count = 64;      // mirror of the programmed vertex count

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  articulation_point_finder_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .edge_from_i   (edge_from),
    .edge_to_i     (edge_to),
    .has_edge_i    (has_edge),
    .last_item_i   (last_item),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_data_i    (cfg_data),
    .result_valid_o(result_valid),
    .cut_vertex_o  (cut_vertex),
    .none_found_o  (none_found),
    .last_result_o (last_result)
  );

  articulation_point_finder_core_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .busy_i        (busy),
    .edge_from_i   (edge_from),
    .edge_to_i     (edge_to),
    .has_edge_i    (has_edge),
    .last_item_i   (last_item),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready),
    .cfg_data_i    (cfg_data),
    .result_valid_i(result_valid),
    .cut_vertex_i  (cut_vertex),
    .none_found_i  (none_found),
    .last_result_i (last_result),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .results_seen_o(results_seen),
    .graphs_seen_o (graphs_seen)
  );

  // Watchdog: a hung search or a lost result ends the run here.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results still owed", cycles, pending);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Bursty sender: random burst lengths separated by random gaps. start only
  // drops when a gap is actually taken, so back-to-back requests keep it high.
  task automatic pace();
    int gap;
    if (steady) return;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    gap = $urandom_range(1, 9);
    burst_left = $urandom_range(0, 12);
    start <= 1'b0;
    repeat (gap) @(posedge clk_i);
  endtask

  // One edge request; returns once the block has taken it (start high, busy low).
  task automatic send(input int a, input int b, input bit he, input bit lst);
    pace();
    start <= 1'b1;
    edge_from <= a[apf_pkg::VtxW-1:0];
    edge_to <= b[apf_pkg::VtxW-1:0];
    has_edge <= he;
    last_item <= lst;
    do @(posedge clk_i); while (busy);
    requests_sent++;
  endtask

  // Let the block drain: every owed result back, then a short settle, since a
  // request that carried an edge keeps the block busy through S_EDGE2.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0 || busy) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Register write, only ever issued from an idle block.
  task automatic set_count(input int n);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= n[apf_pkg::CntW-1:0];
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_count = (n > 64) ? 64 : n;
  endtask

  // Random graph of n vertices: mostly spanning trees (lots of cut vertices)
  // with a few extra edges, plus out-of-range, self-loop and repeated noise.
  task automatic random_graph(input int n);
    int extra, a, b, total;
    bit tail_marker;
    extra = $urandom_range(0, 3);
    tail_marker = $urandom_range(0, 3) == 0;
    total = ((n > 1) ? n - 1 : 0) + extra;
    for (int i = 0; i < total; i++) begin
      if (i < n - 1 && $urandom_range(0, 5) != 0) begin
        a = i + 1;
        b = $urandom_range(0, i);
      end else if ($urandom_range(0, 2) == 0) begin
        a = $urandom_range(0, 63);
        b = $urandom_range(0, 63);
      end else begin
        a = $urandom_range(0, n - 1);
        b = $urandom_range(0, n - 1);
      end
      send(a, b, 1'b1, !tail_marker && i == total - 1);
    end
    if (tail_marker || total == 0)
      send($urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 1), 1'b1);
  endtask

  initial begin
    int n;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part.
    steady = 1;
    // single vertex, bare end marker: none found
    set_count(1);
    send(0, 0, 1'b0, 1'b1);
    // empty graph, end marker carrying an edge
    set_count(0);
    send(0, 0, 1'b1, 1'b1);
    // oversized count acts as full size; hub at the top vertex
    set_count(127);
    send(63, 0, 1'b1, 1'b0);
    send(62, 63, 1'b1, 1'b0);
    send(0, 63, 1'b1, 1'b0);
    send(63, 31, 1'b1, 1'b1);
    // path 0-1-2-3-4 with self loop, repeated edge and out-of-range edges
    steady = 0;
    set_count(5);
    send(0, 1, 1'b1, 1'b0);
    send(2, 2, 1'b1, 1'b0);
    send(1, 2, 1'b1, 1'b0);
    send(2, 1, 1'b1, 1'b0);
    send(4, 5, 1'b1, 1'b0);
    send(63, 0, 1'b1, 1'b0);
    send(2, 3, 1'b1, 1'b0);
    send(3, 4, 1'b1, 1'b1);
    // count shrunk after loading: the edge to vertex 40 must be ignored
    set_count(64);
    send(10, 11, 1'b1, 1'b0);
    send(11, 12, 1'b1, 1'b0);
    send(12, 40, 1'b1, 1'b0);
    set_count(13);
    send(0, 0, 1'b0, 1'b1);
    // two-vertex graph, single edge: no cut vertex
    set_count(2);
    send(1, 0, 1'b1, 1'b1);

    // Random part. Every new count waits for an idle block first.
    while (requests_sent < 250) begin
      case ($urandom_range(0, 9))
        0:       n = 64;
        1:       n = $urandom_range(65, 127);
        2:       n = $urandom_range(0, 2);
        default: n = $urandom_range(3, 16);
      endcase
      if ($urandom_range(0, 2) == 0 || n != cur_count) set_count(n);
      steady = ($urandom_range(0, 4) == 0);
      random_graph(cur_count);
    end

    drain();
    repeat (50) @(posedge clk_i);
    $display("covered %0d requests over %0d graphs, %0d cut vertex results checked",
             requests_sent, graphs_seen, results_seen);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
